>>> design/bsos_pkg.sv
// Shared types and constants for the order-selectable sorting core.
`timescale 1ns / 1ps
`default_nettype none

package bsos_pkg;

   // Default capacity of the sorting chain.
   localparam int MAX_ELEMENTS_DEF = 64;

   // One signed data word.
   typedef logic signed [31:0] word_type;

   // Contents of one chain cell as seen by its neighbors.
   typedef struct packed {
      logic     valid;
      word_type value;
   } cell_data_type;

   // Operation applied to all cells of the chain together.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT_DOWN,
      CELL_SHIFT_UP
   } cell_op_type;

endpackage

`default_nettype wire

>>> design/bsos_req_if.sv
// Valid/ready channel that carries input words to the sorting core.
`timescale 1ns / 1ps
`default_nettype none

interface bsos_req_if;
   import bsos_pkg::*;

   logic     valid;
   logic     ready;
   word_type value;
   logic     last_in;

   modport source (output valid, output value, output last_in, input ready);
   modport sink (input valid, input value, input last_in, output ready);
endinterface

`default_nettype wire

>>> design/bsos_rsp_if.sv
// Valid/ready channel that carries sorted result words from the core.
`timescale 1ns / 1ps
`default_nettype none

interface bsos_rsp_if;
   import bsos_pkg::*;

   logic     valid;
   logic     ready;
   word_type sorted_value;
   logic     last_out;
   logic     overflow;

   modport source (output valid, output sorted_value, output last_out, output overflow,
                   input ready);
   modport sink (input valid, input sorted_value, input last_out, input overflow,
                 output ready);
endinterface

`default_nettype wire

>>> design/bsos_cell.sv
// One cell of the insertion chain: holds a word and trades it with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module bsos_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  bsos_pkg::cell_op_type   op,
   input  bsos_pkg::word_type      new_value,
   input  bsos_pkg::cell_data_type below,
   input  wire                    below_lt,
   input  bsos_pkg::cell_data_type above,
   output bsos_pkg::cell_data_type data,
   output logic                   lt
);
   import bsos_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   word_type value_ff;
   word_type value_in;

   // The new word belongs at or below this cell when the cell is empty or larger.
   assign lt   = !valid_ff || (new_value < value_ff);
   assign data = '{valid: valid_ff, value: value_ff};

   // Select the next contents according to the chain operation.
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      case (op)
         CELL_INSERT: begin
            if (lt) begin
               if (below_lt) begin
                  valid_in = below.valid;
                  value_in = below.value;
               end else begin
                  valid_in = 1'b1;
                  value_in = new_value;
               end
            end
         end
         CELL_SHIFT_DOWN: begin
            valid_in = above.valid;
            value_in = above.value;
         end
         CELL_SHIFT_UP: begin
            valid_in = below.valid;
            value_in = below.value;
         end
         default: begin
            valid_in = valid_ff;
            value_in = value_ff;
         end
      endcase
   end

   // Only the valid bit needs a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

>>> design/bubble_sort_order_select_core.sv
// Sorting core: a chain of insertion cells that loads a set and drains it in order.
// Loading takes one word per cycle; the chain stays in ascending order as words arrive.
// After the last word, the set drains one word per cycle while the result side accepts.
// Ascending drain takes words straight from the bottom cell; descending drain first
// shifts the empty top cells out, then one word per cycle from the top cell.
// Synchronous active-high reset empties the chain and clears the order register.
`timescale 1ns / 1ps
`default_nettype none

module bubble_sort_order_select_core #(
   parameter int MAX_ELEMENTS = bsos_pkg::MAX_ELEMENTS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   bsos_req_if.sink    req_bus,
   bsos_rsp_if.source  rsp_bus,
   input  wire         csr_we,
   input  wire         csr_wdata
);
   import bsos_pkg::*;

   localparam int CountWidth = $clog2(MAX_ELEMENTS + 1);

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   state_type             state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth-1:0] remain_ff, remain_in;
   logic                  dropped_ff, dropped_in;
   logic                  ovf_ff, ovf_in;
   logic                  order_ff, order_in;
   logic                  csr_order_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   word_type              rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   cell_op_type           op;
   cell_data_type         cell_q [MAX_ELEMENTS];
   logic                  cell_lt [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0] cell_valid;
   cell_data_type         end_cell;
   logic                  accept;
   logic                  full;
   logic                  advance;

   assign accept  = req_bus.valid && req_bus.ready;
   assign full    = (count_ff == CountWidth'(MAX_ELEMENTS));
   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign end_cell = order_ff ? cell_q[MAX_ELEMENTS-1] : cell_q[0];

   assign req_bus.ready        = (state_ff == ST_LOAD);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.sorted_value = rsp_value_ff;
   assign rsp_bus.last_out     = rsp_last_ff;
   assign rsp_bus.overflow     = rsp_ovf_ff;

   // The chain of cells; the ends see an empty neighbor.
   genvar gi;
   generate
      for (gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_cell
         cell_data_type below_d;
         cell_data_type above_d;
         logic          below_lt_d;

         if (gi == 0) begin : g_bottom
            assign below_d    = '{valid: 1'b0, value: '0};
            assign below_lt_d = 1'b0;
         end else begin : g_lower
            assign below_d    = cell_q[gi-1];
            assign below_lt_d = cell_lt[gi-1];
         end

         if (gi == MAX_ELEMENTS - 1) begin : g_top
            assign above_d = '{valid: 1'b0, value: '0};
         end else begin : g_upper
            assign above_d = cell_q[gi+1];
         end

         bsos_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .op        (op),
            .new_value (req_bus.value),
            .below     (below_d),
            .below_lt  (below_lt_d),
            .above     (above_d),
            .data      (cell_q[gi]),
            .lt        (cell_lt[gi])
         );

         assign cell_valid[gi] = cell_q[gi].valid;
      end
   endgenerate

   // Sequencing of load and drain, and the output word register.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      dropped_in   = dropped_ff;
      ovf_in       = ovf_ff;
      order_in     = order_ff;
      op           = CELL_HOLD;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (!full) begin
                  op = CELL_INSERT;
               end
               if (req_bus.last_in) begin
                  state_in   = ST_DRAIN;
                  remain_in  = full ? count_ff : count_ff + 1'b1;
                  count_in   = '0;
                  ovf_in     = dropped_ff || full;
                  dropped_in = 1'b0;
                  order_in   = csr_order_ff;
               end else if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (advance) begin
               op           = order_ff ? CELL_SHIFT_UP : CELL_SHIFT_DOWN;
               rsp_valid_in = end_cell.valid;
               if (end_cell.valid) begin
                  rsp_value_in = end_cell.value;
                  rsp_last_in  = (remain_ff == CountWidth'(1));
                  rsp_ovf_in   = ovf_ff;
                  remain_in    = remain_ff - 1'b1;
                  if (remain_ff == CountWidth'(1)) begin
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control state, configuration and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         remain_ff    <= '0;
         dropped_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         order_ff     <= 1'b0;
         csr_order_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         dropped_ff   <= dropped_in;
         ovf_ff       <= ovf_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            csr_order_ff <= csr_wdata;
         end
      end
   end

   // Output word payload.
   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // The fill count never passes the chain length.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(MAX_ELEMENTS))
      else $error("fill count beyond chain length");

   // While loading, the occupied cells match the fill count.
   a_cells_match_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> ($countones(cell_valid) == int'(count_ff)))
      else $error("occupied cells disagree with fill count");

   // A drain always has words left to deliver.
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (remain_ff != '0))
      else $error("drain with nothing left");

   // Delivering the final word leaves the chain empty.
   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && advance && end_cell.valid && remain_ff == CountWidth'(1))
      |=> (cell_valid == '0))
      else $error("chain not empty after drain");

endmodule

`default_nettype wire

>>> verif/bubble_sort_order_select_core_tb.sv
// Self-checking testbench for the order-selectable sorting core.
`timescale 1ns / 1ps

module bubble_sort_order_select_core_tb;
   import bsos_pkg::*;

   localparam int CAPACITY = MAX_ELEMENTS_DEF;
   localparam int RSP_HOLD_CYCLES = 400;
   // Long enough for a descending drain to shift out every empty cell.
   localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam word_type MAX_WORD = 32'sh7FFF_FFFF;
   localparam word_type MIN_WORD = 32'sh8000_0000;

   // One sorted word as the core should deliver it.
   typedef struct packed {
      word_type sorted_value;
      logic     last_out;
      logic     overflow;
   } sorted_word_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   bsos_req_if req_bus ();
   bsos_rsp_if rsp_bus ();

   bubble_sort_order_select_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the set being loaded and of the order register.
   word_type        set_words[CAPACITY];
   int              set_count = 0;
   bit              set_dropped = 1'b0;
   bit              order_desc = 1'b0;
   sorted_word_type expected_words[$];

   int error_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // True if word a belongs after word b in the current order.
   function automatic bit goes_after(word_type a, word_type b);
      return order_desc ? (a < b) : (a > b);
   endfunction

   // Sort the kept words of the completed set and queue them as expected results.
   function automatic void expect_sorted_set();
      word_type ordered[$];
      word_type held;
      int j;
      for (int i = 0; i < set_count; i++) ordered.push_back(set_words[i]);
      for (int i = 1; i < set_count; i++) begin
         held = ordered[i];
         j = i;
         while (j > 0 && goes_after(ordered[j - 1], held)) begin
            ordered[j] = ordered[j - 1];
            j--;
         end
         ordered[j] = held;
      end
      for (int k = 0; k < set_count; k++) begin
         expected_words.push_back('{ordered[k], k == set_count - 1, set_dropped});
      end
   endfunction

   // Update the shadow set with one accepted word.
   function automatic void load_word(word_type value, logic last);
      if (set_count < CAPACITY) begin
         set_words[set_count] = value;
         set_count++;
      end else begin
         set_dropped = 1'b1;
      end
      if (last) begin
         expect_sorted_set();
         set_count = 0;
         set_dropped = 1'b0;
      end
   endfunction

   // Random word: small values with many repeats, the extremes, or any pattern.
   function automatic word_type pick_word();
      case ($urandom_range(4))
         0: return $urandom_range(8) - 4;
         1: return $urandom_range(1) ? MAX_WORD : MIN_WORD;
         default: return $urandom();
      endcase
   endfunction

   // Offer one word, with random idle cycles ahead of it, and wait for acceptance.
   // Valid stays high on return so that back-to-back words leave no gap.
   task automatic send_word(word_type value, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      req_bus.last_in <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      load_word(value, last);
   endtask

   // Send count random words; the final one closes the set if asked.
   task automatic send_run(int count, bit closes);
      for (int i = 0; i < count; i++) send_word(pick_word(), closes && i == count - 1);
   endtask

   // Send a fixed list of words as one complete set.
   task automatic send_list(word_type words[$]);
      foreach (words[i]) send_word(words[i], i == words.size() - 1);
   endtask

   // Stop offering words until every expected word has arrived and the core settles.
   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the order register while the core has nothing left to deliver.
   task automatic write_order(logic descending);
      wait_until_drained();
      csr_we <= 1'b1;
      csr_wdata <= descending;
      @(posedge clock);
      order_desc = descending;
      csr_we <= 1'b0;
   endtask

   // Extremes, repeats and a single-word set, sorted ascending.
   task automatic test_ascending_directed();
      write_order(1'b0);
      send_list('{MIN_WORD});
      send_list('{MAX_WORD, MIN_WORD, 0, -1, 1, 32'sh5555_5555, 32'shAAAA_AAAA});
      send_list('{3, -3, 3, 3});
   endtask

   // The same extremes and a single-word set, sorted descending.
   task automatic test_descending_directed();
      write_order(1'b1);
      send_list('{MAX_WORD, MIN_WORD, 0, -1, 1, 32'sh5555_5555, 32'shAAAA_AAAA});
      send_list('{MAX_WORD});
   endtask

   // The order in force at the final word applies to the whole set.
   task automatic test_order_change_mid_set();
      send_word(10, 1'b0);
      send_word(-20, 1'b0);
      send_word(MAX_WORD, 1'b0);
      write_order(1'b0);
      send_word(MIN_WORD, 1'b0);
      send_word(7, 1'b1);
   endtask

   // A set that fills the chain and whose final word is dropped, then a clean set.
   task automatic test_capacity();
      write_order(1'b1);
      send_run(CAPACITY + 1, 1'b1);
      write_order(1'b0);
      send_run(1, 1'b1);
   endtask

   // Hold the result side for a long stretch during a drain, with a second set offered behind it.
   task automatic test_result_hold_off();
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      send_run(10, 1'b0);
      hold_requests <= hold_requests + 1;
      send_word(pick_word(), 1'b1);
      send_run(5, 1'b1);
      wait_until_drained();
   endtask

   // Random sets, mostly short, some longer, some reordered mid-set.
   task automatic test_random_phase(int items, int idle_pct, int stall_pct);
      int sent;
      int length;
      int split;
      sent = 0;
      send_idle_pct = idle_pct;
      rsp_stall_pct <= stall_pct;
      write_order(1'($urandom_range(1)));
      while (sent < items) begin
         if ($urandom_range(9) == 0) length = $urandom_range(9, 16);
         else length = $urandom_range(1, 8);
         if (length > 1 && $urandom_range(7) == 0) begin
            split = $urandom_range(1, length - 1);
            send_run(split, 1'b0);
            write_order(1'($urandom_range(1)));
            send_run(length - split, 1'b1);
         end else begin
            send_run(length, 1'b1);
         end
         sent += length;
      end
      wait_until_drained();
   endtask

   // Result side: random stalls, plus a long hold-off when one is requested.
   initial begin
      int hold_served;
      int hold_left;
      hold_served = 0;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = RSP_HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Compare each delivered word with the oldest expectation.
   always @(posedge clock) begin
      sorted_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: sorted_value %0d last_out %0b overflow %0b",
                   rsp_bus.sorted_value, rsp_bus.last_out, rsp_bus.overflow);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_bus.sorted_value !== want.sorted_value) begin
               $error("sorted_value: expected %0d, actual %0d",
                      want.sorted_value, rsp_bus.sorted_value);
               error_count++;
            end
            if (rsp_bus.last_out !== want.last_out) begin
               $error("last_out: expected %0b, actual %0b", want.last_out, rsp_bus.last_out);
               error_count++;
            end
            if (rsp_bus.overflow !== want.overflow) begin
               $error("overflow: expected %0b, actual %0b", want.overflow, rsp_bus.overflow);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run if no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_wdata <= 1'b0;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      req_bus.last_in <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_ascending_directed();
      test_descending_directed();
      test_order_change_mid_set();
      test_capacity();
      test_result_hold_off();
      test_random_phase(12, 0, 0);
      test_random_phase(12, 83, 0);
      test_random_phase(12, 0, 83);
      test_random_phase(12, 28, 28);

      wait_until_drained();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> sim.f
design/bsos_pkg.sv
design/bsos_req_if.sv
design/bsos_rsp_if.sv
design/bsos_cell.sv
design/bubble_sort_order_select_core.sv
verif/bubble_sort_order_select_core_tb.sv
